// ===== design/plc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package plc_pkg;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int CNTO_W   = 5;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT_AT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REMOVE_AT  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_READOUT    = 3'd6;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic load;
    logic from_left;
    logic from_right;
    logic from_head;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/plc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module plc_cell (
  input  logic              clk,
  input  plc_pkg::cell_ctl_t ctl,
  input  plc_pkg::data_t    in_val,
  input  plc_pkg::data_t    left_val,
  input  plc_pkg::data_t    right_val,
  input  plc_pkg::data_t    head_val,
  output plc_pkg::data_t    value
);
  import plc_pkg::*;

  always_ff @(posedge clk) begin
    priority if (ctl.load) begin
      value <= in_val;
    end else if (ctl.from_left) begin
      value <= left_val;
    end else if (ctl.from_right) begin
      value <= right_val;
    end else if (ctl.from_head) begin
      value <= head_val;
    end else begin
      value <= value;
    end
  end

endmodule

`default_nettype wire

// ===== design/positional_list_store_top.sv =====
// Positional list store: a bounded ordered list of signed 32-bit values.
// Input channel (in_valid/in_ready) carries cmd, position and item_value;
// output channel (out_valid/out_ready) carries out_value, entry_count,
// status and last. Each command gives one result with last set, except a
// readout of a non-empty list, which gives one result per entry, front first.
// Entries live in a row of cells; an insert or remove shifts the cells from the
// edit position onward in parallel, and the result of an edit command is
// registered and shown the cycle after the transfer.
// A readout spends its transfer cycle starting, then rotates the row one cell
// per cycle while the result register is free and emits cell 0, so its first
// entry shows later than an edit result; the next command is taken after the
// final entry leaves the cell row. The rotation leaves the list as it was.
// in_ready is high when no readout is running and the result register is
// empty or being drained. A stalled receiver holds the result register and
// with it the whole block; nothing is dropped.
// Reset (rst, synchronous) empties the list and the result register.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_store_top #(
  parameter int CAPACITY = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [plc_pkg::CMD_W-1:0]       cmd,
  input  logic [plc_pkg::POS_W-1:0]       position,
  input  logic signed [plc_pkg::DATA_W-1:0] item_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [plc_pkg::DATA_W-1:0] out_value,
  output logic [plc_pkg::CNTO_W-1:0]      entry_count,
  output logic [plc_pkg::STATUS_W-1:0]    status,
  output logic                            last
);
  import plc_pkg::*;

  localparam int UW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = (UW > POS_W) ? UW : POS_W;

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_STREAM = 1'b1;

  logic          state;
  logic [UW-1:0] used;
  logic [UW-1:0] used_next;
  logic [UW-1:0] cnt;

  data_t     cell_val [CAPACITY];
  cell_ctl_t cell_ctl [CAPACITY];

  logic          out_free;
  logic          in_fire;
  logic          step;
  logic          is_push;
  logic          is_pop;
  logic          full;
  logic          empty;
  logic          edit_ins;
  logic          edit_rem;
  logic          start_rd;
  logic          stream_last;
  logic [CW-1:0] pos_c;
  logic [CW-1:0] used_c;
  logic [CW-1:0] used_next_c;
  logic [IW-1:0] ins_at;
  logic [IW-1:0] rem_at;
  logic [IW-1:0] at;
  data_t         rem_val;
  data_t         res_val;
  logic [STATUS_W-1:0] res_status;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;
  assign step     = (state == S_STREAM) && out_free;

  assign is_push = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_BACK) ||
                   (cmd == CMD_INSERT_AT);
  assign is_pop  = (cmd == CMD_POP_FRONT) || (cmd == CMD_POP_BACK) ||
                   (cmd == CMD_REMOVE_AT);
  assign full    = (used == UW'(CAPACITY));
  assign empty   = (used == '0);

  assign edit_ins = in_fire && is_push && !full;
  assign edit_rem = in_fire && is_pop && !empty;
  assign start_rd = in_fire && (cmd == CMD_READOUT) && !empty;

  assign pos_c  = CW'(position);
  assign used_c = CW'(used);

  always_comb begin
    priority if (cmd == CMD_PUSH_FRONT) begin
      ins_at = '0;
    end else if (cmd == CMD_PUSH_BACK) begin
      ins_at = IW'(used);
    end else if (pos_c <= CW'(1)) begin
      ins_at = '0;
    end else if (pos_c >= used_c) begin
      ins_at = IW'(used);
    end else begin
      ins_at = IW'(pos_c - CW'(1));
    end
  end

  always_comb begin
    priority if (cmd == CMD_POP_FRONT) begin
      rem_at = '0;
    end else if (cmd == CMD_POP_BACK) begin
      rem_at = IW'(used - UW'(1));
    end else if (pos_c >= used_c - CW'(1)) begin
      rem_at = IW'(used - UW'(1));
    end else begin
      rem_at = IW'(pos_c);
    end
  end

  assign at = edit_ins ? ins_at : rem_at;

  always_comb begin
    rem_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (rem_at == IW'(i)) begin
        rem_val = rem_val | cell_val[i];
      end
    end
  end

  always_comb begin
    priority if (in_fire && (cmd == CMD_CLEAR)) begin
      used_next = '0;
    end else if (edit_ins) begin
      used_next = used + UW'(1);
    end else if (edit_rem) begin
      used_next = used - UW'(1);
    end else begin
      used_next = used;
    end
  end

  assign used_next_c = CW'(used_next);

  always_comb begin
    res_val    = '0;
    res_status = ST_OK;
    if (is_push && full) begin
      res_status = ST_FULL;
    end else if ((is_pop || (cmd == CMD_READOUT)) && empty) begin
      res_status = ST_EMPTY;
    end else if (is_pop) begin
      res_val = rem_val;
    end
  end

  assign stream_last = ((cnt + UW'(1)) == used);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    data_t left_in;
    data_t right_in;

    if (i == 0) begin : g_first
      assign left_in = item_value;
    end else begin : g_mid_l
      assign left_in = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_in = cell_val[i];
    end else begin : g_mid_r
      assign right_in = cell_val[i+1];
    end

    assign cell_ctl[i].load       = edit_ins && (at == IW'(i));
    assign cell_ctl[i].from_left  = edit_ins && (at < IW'(i)) && (UW'(i) <= used);
    assign cell_ctl[i].from_right = ((edit_rem && (at <= IW'(i))) || step) &&
                                    (UW'(i + 1) < used);
    assign cell_ctl[i].from_head  = step && (UW'(i + 1) == used);

    plc_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .in_val    (item_value),
      .left_val  (left_in),
      .right_val (right_in),
      .head_val  (cell_val[0]),
      .value     (cell_val[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else if (in_fire) begin
      if (start_rd) begin
        state     <= S_STREAM;
        cnt       <= '0;
        out_valid <= 1'b0;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (step) begin
      out_valid <= 1'b1;
      cnt       <= cnt + UW'(1);
      if (stream_last) begin
        state <= S_IDLE;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !start_rd) begin
      out_value   <= res_val;
      entry_count <= used_next_c[CNTO_W-1:0];
      status      <= res_status;
      last        <= 1'b1;
    end else if (step) begin
      out_value   <= cell_val[0];
      entry_count <= used_c[CNTO_W-1:0];
      status      <= ST_OK;
      last        <= stream_last;
    end
  end

  assert property (@(posedge clk) disable iff (rst) used <= UW'(CAPACITY))
    else $error("entry count above capacity");

  assert property (@(posedge clk) disable iff (rst) (state == S_STREAM) |-> (cnt < used))
    else $error("readout index past the end of the list");

  assert property (@(posedge clk) disable iff (rst) (state == S_STREAM) |-> !empty)
    else $error("readout running on an empty list");

  assert property (@(posedge clk) disable iff (rst) (out_valid && !last) |-> (state == S_STREAM))
    else $error("non-final result outside a readout");

  assert property (@(posedge clk) disable iff (rst)
      (state == S_STREAM) |=> (used == $past(used)))
    else $error("list size changed during readout");

endmodule

`default_nettype wire
